FILE: rtl/rab_pkg.sv
// Shared types and constants for the RGB565 alpha-blend pixel writer.
`timescale 1ns / 1ps

package rab_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 8'd3;

  localparam logic [8:0] CLIP_LEFT_RST   = 9'd0;
  localparam logic [7:0] CLIP_TOP_RST    = 8'd0;
  localparam logic [8:0] CLIP_RIGHT_RST  = 9'd320;
  localparam logic [7:0] CLIP_BOTTOM_RST = 8'd240;

  localparam logic CMD_BLEND = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [8:0]  pos_x;
    logic [7:0]  pos_y;
    logic [23:0] colour;
    logic [7:0]  coverage;
  } rab_req_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        written;
  } rab_rsp_t;

endpackage

FILE: rtl/rab_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rab_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rab_blend.sv
// Per-channel coverage blend of a 24-bit colour into a 5-6-5 pixel.
`timescale 1ns / 1ps

module rab_blend (
  input  logic [15:0] old_pixel,
  input  logic [23:0] colour,
  input  logic [7:0]  coverage,
  output logic [15:0] new_pixel
);

  // Exact floor(m / 255) for m up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [16:0] sum;
    sum = {1'b0, m} + 17'd1 + {9'd0, m[15:8]};
    return sum[15:8];
  endfunction

  // old + (new - old) * w / 255, quotient truncated toward zero.
  function automatic logic [7:0] mix(input logic [7:0] old_v, input logic [7:0] new_v,
                                     input logic [7:0] w);
    logic signed [8:0] diff;
    logic              neg;
    logic [7:0]        mag;
    logic [15:0]       prod;
    logic [7:0]        q;
    diff = $signed({1'b0, new_v}) - $signed({1'b0, old_v});
    neg  = diff[8];
    mag  = neg ? 8'(-diff) : diff[7:0];
    prod = {8'd0, mag} * {8'd0, w};
    q    = div255(prod);
    return neg ? (old_v - q) : (old_v + q);
  endfunction

  logic [7:0] r0, g0, b0;
  logic [7:0] r1, g1, b1;

  always_comb begin
    r0 = {old_pixel[4:0], 3'b000};
    g0 = {old_pixel[10:5], 2'b00};
    b0 = {old_pixel[15:11], 3'b000};
    r1 = mix(r0, colour[23:16], coverage);
    g1 = mix(g0, colour[15:8], coverage);
    b1 = mix(b0, colour[7:0], coverage);
    new_pixel = {b1[7:3], g1[7:2], r1[7:3]};
  end

endmodule

FILE: rtl/rgb565_alpha_blend_writer_top.sv
// Top level of the RGB565 alpha-blend pixel writer with scissor clipping.
// Response path: stage 1 (RAM read), then the output register; an untaken rsp stalls stage 1.
// Throughput: one beat per cycle while rsp is taken; set by the read-modify-write
// through the frame RAM's one write port, with forwarding.
// Reset: clip registers take their reset values, then a clearing pass writes zero
// to all 76800 pixels, one per cycle, with req_ready low; cfg writes are taken.
`timescale 1ns / 1ps

module rgb565_alpha_blend_writer_top
  import rab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  rab_req_t              req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rab_rsp_t              rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Scissor rectangle registers.
  logic [8:0] clip_left, clip_right;
  logic [7:0] clip_top, clip_bottom;

  // Clearing pass after reset.
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // Stage 1: item waiting on its RAM read, blended and written on advance.
  logic              s1_valid;
  rab_req_t          s1_req;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_in_frame;
  logic              s1_do_blend;
  logic              s1_fwd_hit;
  logic [15:0]       fwd_pixel;

  logic              accept;
  logic              advance;
  logic              in_frame_new;
  logic              in_clip_new;
  logic [ADDR_W-1:0] addr_new;
  logic [15:0]       ram_q;
  logic [15:0]       old_pixel;
  logic [15:0]       new_pixel;
  logic              item_we;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  rab_rsp_t          rsp_next;

  // Config writes are always taken; the host must write only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= CLIP_LEFT_RST;
      clip_top    <= CLIP_TOP_RST;
      clip_right  <= CLIP_RIGHT_RST;
      clip_bottom <= CLIP_BOTTOM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CLIP_LEFT:   clip_left   <= cfg_data[8:0];
        REG_CLIP_TOP:    clip_top    <= cfg_data[7:0];
        REG_CLIP_RIGHT:  clip_right  <= cfg_data[8:0];
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept  = req_valid && req_ready;
    // Stage 1 moves on whenever the output register is empty or being drained.
    advance = s1_valid && (!rsp_valid || rsp_ready);
    // Take a new request when stage 1 is empty or frees up in the same cycle, but not while clearing.
    req_ready = !clearing && (!s1_valid || advance);

    in_frame_new = (32'(req.pos_x) < FRAME_WIDTH) && (32'(req.pos_y) < FRAME_HEIGHT);
    // An empty rectangle fails one of these compares for every pixel.
    in_clip_new  = (req.pos_x >= clip_left) && (req.pos_x < clip_right)
                && (req.pos_y >= clip_top) && (req.pos_y < clip_bottom);
    addr_new     = ADDR_W'(32'(req.pos_y) * FRAME_WIDTH + 32'(req.pos_x));

    // The RAM reads old data when its address was written on the accept edge;
    // substitute the word that stage 1 wrote then.
    old_pixel = s1_fwd_hit ? fwd_pixel : ram_q;
    item_we   = advance && s1_do_blend;

    // Only the clearing pass or stage 1 ever writes, never both at once.
    ram_we    = clearing || item_we;
    ram_waddr = clearing ? clr_addr : s1_addr;
    ram_wdata = clearing ? 16'd0 : new_pixel;

    rsp_next.written = s1_do_blend;
    if (!s1_in_frame) begin
      rsp_next.pixel = 16'd0;
    end else if (s1_do_blend) begin
      rsp_next.pixel = new_pixel;
    end else begin
      rsp_next.pixel = old_pixel;
    end
  end

  // Sweep the frame once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(PIXEL_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload and forwarding capture; hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req      <= req;
      s1_addr     <= addr_new;
      s1_in_frame <= in_frame_new;
      s1_do_blend <= in_frame_new && in_clip_new && (req.cmd == CMD_BLEND)
                  && (req.coverage != 8'd0);
      s1_fwd_hit  <= item_we && (s1_addr == addr_new);
      fwd_pixel   <= new_pixel;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  rab_ram #(
    .DEPTH (PIXEL_COUNT),
    .WIDTH (16)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && in_frame_new),
    .raddr (addr_new),
    .rdata (ram_q)
  );

  rab_blend u_blend (
    .old_pixel (old_pixel),
    .colour    (s1_req.colour),
    .coverage  (s1_req.coverage),
    .new_pixel (new_pixel)
  );

endmodule
